[rtl/core/lmf_pkg.sv]
package lmf_pkg;

  // store geometry
  localparam int LED_COUNT     = 512;
  localparam int LEDS_PER_ROW  = 16;
  localparam int ROW_COUNT     = (LED_COUNT + LEDS_PER_ROW - 1) / LEDS_PER_ROW;
  localparam int ROW_W         = $clog2(ROW_COUNT);
  localparam int ROWS_PER_RING = 4;
  localparam int IDX_W         = 15;

  // frame layout
  localparam logic [7:0] GRID_HEAD = 8'h1A;
  localparam logic [7:0] RING_HEAD = 8'h92;
  localparam int GRID_FRAME_LEN = 35;
  localparam int RING_FRAME_LEN = 34;
  localparam int WORD_BYTES     = 8;
  localparam int DATA_BYTES     = 32;
  localparam int LAST_WORD      = GRID_FRAME_LEN / WORD_BYTES;
  localparam int GRID_ROWS      = 8;
  localparam int GRID_QUADS     = 4;
  localparam int RING_FRAMES    = 8;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // input modes
  localparam logic [2:0] MODE_SET_GRID  = 3'd0;
  localparam logic [2:0] MODE_SET_RING  = 3'd1;
  localparam logic [2:0] MODE_CLEAR_ALL = 3'd2;
  localparam logic [2:0] MODE_CLR_RING  = 3'd3;
  localparam logic [2:0] MODE_MARK      = 3'd4;
  localparam logic [2:0] MODE_REFRESH   = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_SET      = 3'd1,
    OP_CLR_ALL  = 3'd2,
    OP_CLR_RING = 3'd3,
    OP_MARK     = 3'd4,
    OP_REFRESH  = 3'd5
  } lmf_op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] column_or_position;
    logic [7:0] row_or_ring;
    logic [3:0] level;
    logic       mark_ring_set;
  } lmf_in_t;

  typedef struct packed {
    logic [63:0] frame_bytes;
    logic [3:0]  byte_count;
    logic        frame_end;
    logic        last;
  } lmf_out_t;

  typedef struct packed {
    lmf_op_t          op;
    logic [ROW_W-1:0] row;
    logic [3:0]       nib;
    logic [3:0]       level;
    logic [7:0]       ring;
    logic             sel;
  } lmf_cmd_t;

endpackage

[rtl/core/led_level_map_framer.sv]
// an accepted command is queued, then executed from the queue head by the idle back end
// a refresh goes through queue, row fetch, wait and output register to its first word
// throughput: set, clear and mark words run at one per cycle while no refresh is active
// refresh: grid frames read 8 rows, wait, send 5 words; ring frames read half the rows
// the refresh sequencer holds the four-entry queue; input stalls only when it is full
// reset: synchronous active-low, clears flags, queue and per-row valid bits
module led_level_map_framer import lmf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lmf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lmf_out_t out_data
);

  logic     f_valid;
  lmf_cmd_t f_cmd;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  lmf_cmd_t q_cmd;

  assign in_stall = q_full;

  // decode incoming words
  lmf_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd       (f_cmd)
  );

  // command queue between front and back
  lmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_cmd  (f_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  // store, flags and frame output
  lmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/lmf_front.sv]
module lmf_front import lmf_pkg::*; (
  input  logic     in_valid,
  input  lmf_in_t  in_data,
  output logic     cmd_valid,
  output lmf_cmd_t cmd
);

  logic [IDX_W-1:0] idx_grid;
  logic [IDX_W-1:0] idx_ring;
  logic [IDX_W-1:0] idx;
  logic             in_range;

  // store index for grid and ring addressing
  assign idx_grid = {7'd0, in_data.column_or_position} + {3'd0, in_data.row_or_ring, 4'd0};
  assign idx_ring = {7'd0, in_data.column_or_position} + {1'b0, in_data.row_or_ring, 6'd0};
  assign idx      = (in_data.mode == MODE_SET_RING) ? idx_ring : idx_grid;
  assign in_range = idx < IDX_W'(LED_COUNT);

  // classify the word into a command
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.row   = idx[ROW_W+3:4];
    cmd.nib   = idx[3:0];
    cmd.level = in_data.level;
    cmd.ring  = in_data.row_or_ring;
    cmd.sel   = in_data.mark_ring_set;
    case (in_data.mode)
      MODE_SET_GRID, MODE_SET_RING: begin
        cmd.op = in_range ? OP_SET : OP_NONE;
      end
      MODE_CLEAR_ALL: cmd.op = OP_CLR_ALL;
      MODE_CLR_RING:  cmd.op = OP_CLR_RING;
      MODE_MARK:      cmd.op = OP_MARK;
      MODE_REFRESH:   cmd.op = OP_REFRESH;
      default:        cmd.op = OP_NONE;
    endcase
  end

  assign cmd_valid = in_valid && (cmd.op != OP_NONE);

endmodule

[rtl/core/lmf_queue.sv]
module lmf_queue import lmf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lmf_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output lmf_cmd_t pop_cmd
);

  lmf_cmd_t        slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wp_r, wp_nxt;
  logic [QP_W-1:0] rp_r, rp_nxt;
  logic [QP_W:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full      = cnt_r == (QP_W+1)'(QUEUE_DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_cmd   = slot_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // pointer and fill count update
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QP_W+1)'(do_push) - (QP_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/lmf_back.sv]
module lmf_back import lmf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  lmf_cmd_t cmd,
  output logic     cmd_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output lmf_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_WAIT  = 4'b0100,
    S_SEND  = 4'b1000
  } lmf_state_t;

  lmf_state_t st_r, st_nxt;

  logic [63:0] mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] rv_r, rv_nxt;
  logic grid_dirty_r, grid_dirty_nxt;
  logic ring_dirty_r, ring_dirty_nxt;

  logic       do_ring_r, do_ring_nxt;
  logic       phase_ring_r, phase_ring_nxt;
  logic [2:0] fno_r, fno_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] wcnt_r, wcnt_nxt;

  // store write port
  logic             mem_we;
  logic [ROW_W-1:0] mem_wa;
  logic [15:0]      mem_mask;
  logic [63:0]      mem_wdata;

  // store read port
  logic [4:0]       row5;
  logic             row_ok;
  logic [ROW_W-1:0] rd_addr;
  logic [63:0]      mem_rd_r;
  logic             rd_ok_r;
  logic             rd_pend_r;
  logic [2:0]       rd_slot_r;
  logic             rd_issue;

  logic [31:0][7:0] fbuf_r;
  logic [63:0]      rd_row;
  logic [31:0]      rd_half;

  logic       out_valid_r;
  lmf_out_t   out_data_r;
  logic       out_load;
  lmf_out_t   word;
  logic [2:0][7:0] hdr;
  logic [1:0] hl;
  logic       last_frame;

  assign cmd_pop = (st_r == S_IDLE) && cmd_valid;

  // command execution and refresh sequencing
  always_comb begin
    st_nxt         = st_r;
    rv_nxt         = rv_r;
    grid_dirty_nxt = grid_dirty_r;
    ring_dirty_nxt = ring_dirty_r;
    do_ring_nxt    = do_ring_r;
    phase_ring_nxt = phase_ring_r;
    fno_nxt        = fno_r;
    cnt_nxt        = cnt_r;
    wcnt_nxt       = wcnt_r;
    mem_we         = 1'b0;
    mem_wa         = cmd.row;
    mem_mask       = '0;
    mem_wdata      = {16{cmd.level}};
    rd_issue       = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_SET: begin
              mem_we = 1'b1;
              rv_nxt[cmd.row] = 1'b1;
              if (rv_r[cmd.row]) begin
                mem_mask = 16'd1 << cmd.nib;
              end else begin
                // first write of a cleared row zeroes its other leds
                mem_mask = '1;
                for (int i = 0; i < 16; i++) begin
                  mem_wdata[4*i +: 4] = (cmd.nib == 4'(i)) ? cmd.level : 4'd0;
                end
              end
            end
            OP_CLR_ALL: rv_nxt = '0;
            OP_CLR_RING: begin
              for (int k = 0; k < ROW_COUNT; k++) begin
                if (8'(k / ROWS_PER_RING) == cmd.ring) begin
                  rv_nxt[k] = 1'b0;
                end
              end
            end
            OP_MARK: begin
              if (cmd.sel) begin
                ring_dirty_nxt = 1'b1;
              end else begin
                grid_dirty_nxt = 1'b1;
              end
            end
            OP_REFRESH: begin
              if (grid_dirty_r || ring_dirty_r) begin
                do_ring_nxt    = ring_dirty_r;
                phase_ring_nxt = !grid_dirty_r;
                fno_nxt        = '0;
                cnt_nxt        = '0;
                grid_dirty_nxt = 1'b0;
                ring_dirty_nxt = 1'b0;
                st_nxt         = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        rd_issue = 1'b1;
        if (cnt_r == (phase_ring_r ? 3'(ROWS_PER_RING - 1) : 3'(GRID_ROWS - 1))) begin
          st_nxt = S_WAIT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_WAIT: begin
        wcnt_nxt = '0;
        st_nxt   = S_SEND;
      end
      S_SEND: begin
        if (out_load) begin
          if (wcnt_r == 3'(LAST_WORD)) begin
            wcnt_nxt = '0;
            cnt_nxt  = '0;
            if (!phase_ring_r && fno_r == 3'(GRID_QUADS - 1)) begin
              if (do_ring_r) begin
                phase_ring_nxt = 1'b1;
                fno_nxt        = '0;
                st_nxt         = S_FETCH;
              end else begin
                st_nxt = S_IDLE;
              end
            end else if (phase_ring_r && fno_r == 3'(RING_FRAMES - 1)) begin
              st_nxt = S_IDLE;
            end else begin
              fno_nxt = fno_r + 3'd1;
              st_nxt  = S_FETCH;
            end
          end else begin
            wcnt_nxt = wcnt_r + 3'd1;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      rv_r         <= '0;
      grid_dirty_r <= 1'b0;
      ring_dirty_r <= 1'b0;
      do_ring_r    <= 1'b0;
      phase_ring_r <= 1'b0;
      fno_r        <= '0;
      cnt_r        <= '0;
      wcnt_r       <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      rv_r         <= rv_nxt;
      grid_dirty_r <= grid_dirty_nxt;
      ring_dirty_r <= ring_dirty_nxt;
      do_ring_r    <= do_ring_nxt;
      phase_ring_r <= phase_ring_nxt;
      fno_r        <= fno_nxt;
      cnt_r        <= cnt_nxt;
      wcnt_r       <= wcnt_nxt;
      rd_pend_r    <= rd_issue;
      out_valid_r  <= out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    end
  end

  // level store, nibble write mask, registered read
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (mem_we && mem_mask[i]) begin
        mem[mem_wa][4*i +: 4] <= mem_wdata[4*i +: 4];
      end
    end
    mem_rd_r <= mem[rd_addr];
  end

  // fetch row address for the current quadrant or ring
  assign row5    = phase_ring_r ? {fno_r, cnt_r[1:0]} : {1'b0, fno_r[1], cnt_r};
  assign row_ok  = {1'b0, row5} < 6'(ROW_COUNT);
  assign rd_addr = row5[ROW_W-1:0];

  always_ff @(posedge clk) begin
    rd_ok_r   <= row_ok && rv_r[rd_addr];
    rd_slot_r <= cnt_r;
  end

  // pack fetched rows into the frame data buffer
  assign rd_row  = rd_ok_r ? mem_rd_r : 64'd0;
  assign rd_half = fno_r[0] ? rd_row[63:32] : rd_row[31:0];

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      if (phase_ring_r) begin
        for (int j = 0; j < 8; j++) begin
          fbuf_r[{rd_slot_r[1:0], 3'(j)}] <= {rd_row[8*j +: 4], rd_row[8*j+4 +: 4]};
        end
      end else begin
        for (int j = 0; j < 4; j++) begin
          fbuf_r[{rd_slot_r, 2'(j)}] <= {rd_half[8*j +: 4], rd_half[8*j+4 +: 4]};
        end
      end
    end
  end

  // build the next output word
  always_comb begin
    logic [5:0] k;
    logic [5:0] di;
    hdr[0] = phase_ring_r ? RING_HEAD : GRID_HEAD;
    hdr[1] = phase_ring_r ? {5'd0, fno_r} : (fno_r[0] ? 8'd8 : 8'd0);
    hdr[2] = fno_r[1] ? 8'd8 : 8'd0;
    hl     = phase_ring_r ? 2'd2 : 2'd3;
    last_frame = phase_ring_r ? (fno_r == 3'(RING_FRAMES - 1))
                              : (fno_r == 3'(GRID_QUADS - 1) && !do_ring_r);
    word = '0;
    for (int b = 0; b < WORD_BYTES; b++) begin
      k  = {wcnt_r, 3'(b)};
      di = k - {4'd0, hl};
      if (k < {4'd0, hl}) begin
        word.frame_bytes[8*b +: 8] = hdr[k[1:0]];
      end else if (di < 6'(DATA_BYTES)) begin
        word.frame_bytes[8*b +: 8] = fbuf_r[di[4:0]];
      end
    end
    if (wcnt_r == 3'(LAST_WORD)) begin
      word.byte_count = phase_ring_r ? 4'(RING_FRAME_LEN - LAST_WORD * WORD_BYTES)
                                     : 4'(GRID_FRAME_LEN - LAST_WORD * WORD_BYTES);
      word.frame_end  = 1'b1;
      word.last       = last_frame;
    end else begin
      word.byte_count = 4'(WORD_BYTES);
    end
  end

  // output register
  assign out_load = (st_r == S_SEND) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last |-> out_data_r.frame_end)
    else $error("last word does not end a frame");

  a_short_word_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.byte_count != 4'(WORD_BYTES) |-> out_data_r.frame_end)
    else $error("short word in the middle of a frame");

  a_no_pop_in_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !cmd_pop && !mem_we)
    else $error("command executed during refresh");

  a_flags_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) && cmd_valid && cmd.op == OP_REFRESH |=>
      !grid_dirty_r && !ring_dirty_r)
    else $error("dirty flags survive a refresh");

endmodule
